>>> sv/matrix_keypad_scan_debounce_defines.svh
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared concurrent assertion forms for the keypad scanner checkers.
// ----------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH
`define MATRIX_KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define MKS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked during reset as well
`define MKS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/mks_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Types and constants shared by the keypad scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mks_pkg;

    localparam int ROW_W       = 4;
    localparam int COL_W       = 2;
    localparam int CODE_W      = 4;
    localparam int SETTLE_W    = 16;
    localparam int TDATA_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd4;
    localparam logic [COL_W-1:0]    LAST_COL     = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_CAPTURE,
        PH_WATCH
    } phase_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] row;
    } row_class_t;

endpackage

`default_nettype wire

>>> sv/mks_front.sv
// ----------------------------------------------------------------------------
// Keypad scanner front end
// Accepts row words and priority-encodes the active-low row lines.
// ----------------------------------------------------------------------------
`default_nettype none

module mks_front
(
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [mks_pkg::ROW_W-1:0] row_sense,
    input  wire logic                      q_full,
    output logic                           q_push,
    output mks_pkg::row_class_t            q_data
);

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Row 3 has the highest priority
    always_comb
    begin
        q_data.hit = !(&row_sense);
        if (!row_sense[3])
        begin
            q_data.row = 2'd3;
        end
        else if (!row_sense[2])
        begin
            q_data.row = 2'd2;
        end
        else if (!row_sense[1])
        begin
            q_data.row = 2'd1;
        end
        else
        begin
            q_data.row = 2'd0;
        end
    end

endmodule

`default_nettype wire

>>> sv/mks_queue.sv
// ----------------------------------------------------------------------------
// Keypad scanner queue
// Short FIFO of classified row words between front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module mks_queue
#(
    parameter int DEPTH = mks_pkg::QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire mks_pkg::row_class_t push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     valid,
    output mks_pkg::row_class_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mks_pkg::row_class_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign valid    = (count_reg != '0);
    assign pop_data = entries_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/mks_back.sv
// ----------------------------------------------------------------------------
// Keypad scanner back end
// Steps the scan and debounce state machine and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module mks_back
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [mks_pkg::SETTLE_W-1:0] cfg_data,
    input  wire logic                         q_valid,
    input  wire mks_pkg::row_class_t          q_data,
    output logic                              q_pop,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [mks_pkg::TDATA_W-1:0]       m_axis_tdata
);

    mks_pkg::phase_t phase_reg, phase_next;
    logic [mks_pkg::COL_W-1:0]    col_reg, col_next, col_frame;
    logic [mks_pkg::SETTLE_W-1:0] count_reg, count_next, count_dec;
    logic [mks_pkg::SETTLE_W-1:0] settle_ticks_reg;
    logic [mks_pkg::CODE_W-1:0]   held_reg, held_next, code, report;
    logic                         valid, frame_none;
    logic                         tvalid_reg, tvalid_next;
    logic [mks_pkg::TDATA_W-1:0]  tdata_reg, tdata_next;

    assign q_pop         = q_valid && (!tvalid_reg || m_axis_tready);
    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;

    assign code       = {col_reg, q_data.row};
    assign frame_none = !q_data.hit && (col_reg == mks_pkg::LAST_COL);
    assign col_frame  = (q_data.hit || col_reg == mks_pkg::LAST_COL) ? '0 : col_reg + 1'b1;
    assign count_dec  = (count_reg != '0) ? count_reg - 1'b1 : count_reg;

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        count_next = count_reg;
        held_next  = held_reg;
        valid      = 1'b0;
        report     = '0;
        if (q_pop)
        begin
            unique case (phase_reg)
                mks_pkg::PH_IDLE:
                begin
                    col_next = col_frame;
                    if (q_data.hit)
                    begin
                        if (settle_ticks_reg == '0)
                        begin
                            phase_next = mks_pkg::PH_CAPTURE;
                        end
                        else
                        begin
                            count_next = settle_ticks_reg;
                            phase_next = mks_pkg::PH_SETTLE;
                        end
                    end
                end
                mks_pkg::PH_SETTLE:
                begin
                    col_next   = '0;
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        phase_next = mks_pkg::PH_CAPTURE;
                    end
                end
                mks_pkg::PH_CAPTURE:
                begin
                    col_next = col_frame;
                    if (q_data.hit)
                    begin
                        held_next  = code;
                        phase_next = mks_pkg::PH_WATCH;
                    end
                    else if (frame_none)
                    begin
                        phase_next = mks_pkg::PH_IDLE;
                    end
                end
                mks_pkg::PH_WATCH:
                begin
                    col_next = col_frame;
                    if (frame_none || (q_data.hit && code != held_reg))
                    begin
                        valid      = 1'b1;
                        report     = held_reg;
                        phase_next = mks_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = mks_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        tvalid_next = tvalid_reg && !m_axis_tready;
        tdata_next  = tdata_reg;
        if (q_pop)
        begin
            tvalid_next = 1'b1;
            tdata_next  = {1'b0, report, valid, col_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= mks_pkg::PH_IDLE;
            col_reg          <= '0;
            count_reg        <= '0;
            held_reg         <= '0;
            settle_ticks_reg <= mks_pkg::SETTLE_RESET;
            tvalid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            col_reg    <= col_next;
            count_reg  <= count_next;
            held_reg   <= held_next;
            tvalid_reg <= tvalid_next;
            if (cfg_we)
            begin
                settle_ticks_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tdata_reg <= tdata_next;
    end

endmodule

`default_nettype wire

>>> sv/matrix_keypad_scan_debounce.sv
// ----------------------------------------------------------------------------
// 4x4 matrix keypad scanner with debounce
// Scans one column per word, debounces, reports released or changed keys.
// ----------------------------------------------------------------------------
// Each input word carries the active-low row lines of the column named by the
// previous result word; every input word yields exactly one result word. The
// block sustains one word per clock cycle unless the output stalls: the front
// end encodes the rows into a two-entry queue, and the back-end state machine
// takes one queued word per cycle into the output register, so each word is
// registered in the queue and then in the output register. s_axis_tready drops
// only when the queue is full because the output side is stalled.
`default_nettype none

module matrix_keypad_scan_debounce
#(
    parameter int QUEUE_DEPTH = mks_pkg::QUEUE_DEPTH
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [mks_pkg::SETTLE_W-1:0] cfg_data,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [mks_pkg::TDATA_W-1:0]  s_axis_tdata,  // [3:0] row_sense
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [1:0] column_drive, [2] key_valid, [6:3] key_code
    output logic [mks_pkg::TDATA_W-1:0]       m_axis_tdata
);

    logic                q_push, q_full, q_pop, q_valid;
    mks_pkg::row_class_t q_in, q_out;

    mks_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .row_sense     (s_axis_tdata[mks_pkg::ROW_W-1:0]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    mks_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    mks_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> sv/mks_checker.sv
// ----------------------------------------------------------------------------
// Keypad scanner port checker
// Port-level assertions on the keypad scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "matrix_keypad_scan_debounce_defines.svh"

module mks_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        m_axis_tvalid,
    input wire logic                        m_axis_tready,
    input wire logic [mks_pkg::TDATA_W-1:0] m_axis_tdata
);

    `MKS_ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")
    `MKS_ASSERT_CLK(a_report_col0, clk, rst_n, m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'd0, "key report without frame restart")
    `MKS_ASSERT_CLK(a_code_zero, clk, rst_n, m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[6:3] == 4'd0, "key code set without key_valid")
    `MKS_ASSERT_ALWAYS(a_no_out_in_reset, clk, !rst_n |-> !m_axis_tvalid, "result word offered in reset")

endmodule

bind matrix_keypad_scan_debounce mks_checker u_mks_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
